>>> hw/rtl/cle_pkg.sv
// Shared types and codes for the circular list engine.
package cle_pkg;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_END   = 3'd1,
      CMD_INS_AFTER = 3'd2,
      CMD_DELETE    = 3'd3,
      CMD_READ      = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_POS      = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_TAKE,
      S_INS_A,
      S_INS_B,
      S_INS_C,
      S_DEL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic val_we;
      logic nxt_we;
   } mem_ctl_type;

endpackage

>>> hw/rtl/circular_list_engine_top.sv
// A rejected or unused command goes from S_CHECK straight to the result strobe. Insert at
// front or end passes S_TAKE, S_INS_A, S_INS_B and S_INS_C (into an empty list it ends
// after S_INS_A); a read walks to its position; insert after walks there first; a delete
// walks to a match or the list's end, then frees the node in S_DEL. The walk takes one link
// per cycle through the single registered read port of the node pool. A new word is taken
// in the cycle after the strobe. The receiver cannot stall. Synchronous reset empties the list.
module circular_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [4:0]         rsp_length,
   output logic signed [31:0] rsp_read_value
);
   import cle_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   mem_ctl_type   ctl;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] val_waddr;
   logic [31:0]   val_wdata;
   logic [IW-1:0] nxt_waddr;
   logic [IW-1:0] nxt_wdata;
   logic [IW-1:0] rd_addr_q;
   logic [31:0]   val_rdata;
   logic [IW-1:0] nxt_rdata;
   logic [CW-1:0] count;

   cle_node_mem #(
      .CAPACITY (CAPACITY),
      .IW       (IW)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .val_waddr (val_waddr),
      .val_wdata (val_wdata),
      .nxt_waddr (nxt_waddr),
      .nxt_wdata (nxt_wdata),
      .rd_addr_q (rd_addr_q),
      .val_rdata (val_rdata),
      .nxt_rdata (nxt_rdata)
   );

   cle_seq #(
      .CAPACITY (CAPACITY),
      .IW       (IW),
      .CW       (CW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_command  (req_command),
      .req_position (req_position),
      .req_value    (req_value),
      .busy         (busy),
      .done         (rsp_valid),
      .status       (rsp_status),
      .count        (count),
      .read_value   (rsp_read_value),
      .ctl          (ctl),
      .rd_addr      (rd_addr),
      .val_waddr    (val_waddr),
      .val_wdata    (val_wdata),
      .nxt_waddr    (nxt_waddr),
      .nxt_wdata    (nxt_wdata),
      .rd_addr_q    (rd_addr_q),
      .val_rdata    (val_rdata),
      .nxt_rdata    (nxt_rdata)
   );

   // Length is reported modulo 32.
   assign rsp_length = 5'(count);

endmodule

>>> hw/rtl/cle_node_mem.sv
// Node pool storage: value and next-link memories with one registered read port.
module cle_node_mem #(
   parameter int CAPACITY = 16,
   parameter int IW       = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  cle_pkg::mem_ctl_type ctl,
   input  logic [IW-1:0]      rd_addr,
   input  logic [IW-1:0]      val_waddr,
   input  logic [31:0]        val_wdata,
   input  logic [IW-1:0]      nxt_waddr,
   input  logic [IW-1:0]      nxt_wdata,
   output logic [IW-1:0]      rd_addr_q,
   output logic [31:0]        val_rdata,
   output logic [IW-1:0]      nxt_rdata
);
   import cle_pkg::*;

   logic [31:0]         val_mem [CAPACITY];
   logic [IW-1:0]       nxt_mem [CAPACITY];
   logic [CAPACITY-1:0] nxt_vld_ff;
   logic [IW-1:0]       nxt_raw_ff;
   logic                nxt_hit_ff;
   logic [IW-1:0]       addr_ff;
   logic [31:0]         val_rd_ff;
   logic [IW-1:0]       chain_next;

   always_ff @(posedge clock) begin
      if (ctl.val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      if (ctl.nxt_we) begin
         nxt_mem[nxt_waddr] <= nxt_wdata;
      end
      val_rd_ff  <= val_mem[rd_addr];
      nxt_raw_ff <= nxt_mem[rd_addr];
      nxt_hit_ff <= nxt_vld_ff[rd_addr];
      addr_ff    <= rd_addr;
   end

   // A link never written reads as the free chain laid out at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_vld_ff <= '0;
      end else if (ctl.nxt_we) begin
         nxt_vld_ff[nxt_waddr] <= 1'b1;
      end
   end

   always_comb begin
      if (addr_ff == IW'(CAPACITY - 1)) begin
         chain_next = '0;
      end else begin
         chain_next = IW'(addr_ff + 1'b1);
      end
   end

   assign rd_addr_q = addr_ff;
   assign val_rdata = val_rd_ff;
   assign nxt_rdata = nxt_hit_ff ? nxt_raw_ff : chain_next;

endmodule

>>> hw/rtl/cle_seq.sv
// Command sequencer: walks the list one link per cycle through the shared read port.
module cle_seq #(
   parameter int CAPACITY = 16,
   parameter int IW       = 4,
   parameter int CW       = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_command,
   input  logic [7:0]           req_position,
   input  logic signed [31:0]   req_value,
   output logic                 busy,
   output logic                 done,
   output logic [2:0]           status,
   output logic [CW-1:0]        count,
   output logic signed [31:0]   read_value,
   output cle_pkg::mem_ctl_type ctl,
   output logic [IW-1:0]        rd_addr,
   output logic [IW-1:0]        val_waddr,
   output logic [31:0]          val_wdata,
   output logic [IW-1:0]        nxt_waddr,
   output logic [IW-1:0]        nxt_wdata,
   input  logic [IW-1:0]        rd_addr_q,
   input  logic [31:0]          val_rdata,
   input  logic [IW-1:0]        nxt_rdata
);
   import cle_pkg::*;

   localparam int PW = (CW > 8) ? CW : 8;

   state_type       state_ff, state_in;
   logic [2:0]      cmd_ff, cmd_in;
   logic [7:0]      pos_ff, pos_in;
   logic [31:0]     val_ff, val_in;
   logic [IW-1:0]   tail_ff, tail_in;
   logic [IW-1:0]   free_ff, free_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   k_ff, k_in;
   logic [IW-1:0]   link_ff, link_in;
   logic [IW-1:0]   new_ff, new_in;
   logic [IW-1:0]   cur_ff, cur_in;
   logic [IW-1:0]   prev_ff, prev_in;
   logic [2:0]      status_ff, status_in;
   logic [31:0]     rd_ff, rd_in;

   logic            is_empty;
   logic            is_full;
   logic            pos_bad;
   logic            at_pos;
   logic [PW-1:0]   pos_x;
   logic [PW-1:0]   cnt_x;
   logic [PW-1:0]   k_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tail_ff  <= '0;
         free_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      k_ff      <= k_in;
      link_ff   <= link_in;
      new_ff    <= new_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
   end

   assign pos_x    = PW'(pos_ff);
   assign cnt_x    = PW'(count_ff);
   assign k_x      = PW'(k_ff);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign pos_bad  = (pos_ff == 8'd0) || (pos_x > cnt_x);
   assign at_pos   = (k_x == pos_x);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      tail_in   = tail_ff;
      free_in   = free_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      link_in   = link_ff;
      new_in    = new_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      ctl       = '0;
      rd_addr   = '0;
      val_waddr = free_ff;
      val_wdata = val_ff;
      nxt_waddr = '0;
      nxt_wdata = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_command;
               pos_in    = req_position;
               val_in    = req_value;
               status_in = ST_OK;
               rd_in     = '0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            // The walk starts at the tail, which counts as position zero.
            k_in    = '0;
            rd_addr = tail_ff;
            case (cmd_ff)
               CMD_INS_FRONT, CMD_INS_END: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     link_in  = tail_ff;
                     state_in = S_TAKE;
                  end
               end
               CMD_INS_AFTER: begin
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else if (pos_bad) begin
                     status_in = ST_POS;
                     state_in  = S_DONE;
                  end else if (is_full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               CMD_DELETE: begin
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               CMD_READ: begin
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else if (pos_bad) begin
                     status_in = ST_POS;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WALK: begin
            // The read port holds the value and link of the node at position k.
            rd_addr = nxt_rdata;
            prev_in = rd_addr_q;
            k_in    = CW'(k_ff + 1'b1);
            case (cmd_ff)
               CMD_READ: begin
                  if (at_pos) begin
                     rd_in    = val_rdata;
                     state_in = S_DONE;
                  end
               end
               CMD_INS_AFTER: begin
                  if (at_pos) begin
                     link_in  = rd_addr_q;
                     state_in = S_TAKE;
                  end
               end
               CMD_DELETE: begin
                  if ((k_ff != '0) && (val_rdata == val_ff)) begin
                     cur_in     = rd_addr_q;
                     prev_in    = prev_ff;
                     ctl.nxt_we = 1'b1;
                     nxt_waddr  = prev_ff;
                     nxt_wdata  = nxt_rdata;
                     state_in   = S_DEL;
                  end else if (k_ff == count_ff) begin
                     status_in = ST_NOTFOUND;
                     state_in  = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_TAKE: begin
            rd_addr    = free_ff;
            ctl.val_we = 1'b1;
            new_in     = free_ff;
            state_in   = S_INS_A;
         end
         S_INS_A: begin
            free_in = nxt_rdata;
            rd_addr = link_ff;
            if (is_empty) begin
               ctl.nxt_we = 1'b1;
               nxt_waddr  = new_ff;
               nxt_wdata  = new_ff;
               tail_in    = new_ff;
               count_in   = CW'(count_ff + 1'b1);
               state_in   = S_DONE;
            end else begin
               state_in = S_INS_B;
            end
         end
         S_INS_B: begin
            ctl.nxt_we = 1'b1;
            nxt_waddr  = new_ff;
            nxt_wdata  = nxt_rdata;
            state_in   = S_INS_C;
         end
         S_INS_C: begin
            ctl.nxt_we = 1'b1;
            nxt_waddr  = link_ff;
            nxt_wdata  = new_ff;
            if ((cmd_ff == CMD_INS_END) ||
                ((cmd_ff == CMD_INS_AFTER) && (link_ff == tail_ff))) begin
               tail_in = new_ff;
            end
            count_in = CW'(count_ff + 1'b1);
            state_in = S_DONE;
         end
         S_DEL: begin
            // The removed node goes back on top of the free list.
            ctl.nxt_we = 1'b1;
            nxt_waddr  = cur_ff;
            nxt_wdata  = free_ff;
            free_in    = cur_ff;
            count_in   = CW'(count_ff - 1'b1);
            if (count_ff == CW'(1)) begin
               tail_in = '0;
            end else if (cur_ff == tail_ff) begin
               tail_in = prev_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign done       = (state_ff == S_DONE);
   assign status     = status_ff;
   assign count      = count_ff;
   assign read_value = rd_ff;

endmodule

>>> hw/rtl/cle_checker.sv
// Port-level checker for the circular list engine and its bind to the top level.
module cle_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [2:0]         rsp_status,
   input logic signed [31:0] rsp_read_value
);
   import cle_pkg::*;

   // A command taken while idle makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after a word was accepted");

   a_result_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy period");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block did not return to idle after its result");

   a_read_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_read_value == 32'sd0))
      else $error("nonzero read value with an error status");

endmodule

bind circular_list_engine_top cle_checker u_cle_checker (.*);
